// ===== hw/rtl/fpa_pkg.sv =====
package fpa_pkg;

    localparam int DATA_WIDTH    = 32;
    localparam int FRACTION_BITS = 8;
    localparam int IO_WIDTH      = 32;

    // divider: restoring, DIV_STEPS quotient bits per stage
    localparam int DIV_STEPS  = 4;
    localparam int NUM_WIDTH  = DATA_WIDTH + FRACTION_BITS;
    localparam int DIV_STAGES = (NUM_WIDTH + DIV_STEPS - 1) / DIV_STEPS;
    localparam int QUO_WIDTH  = DIV_STAGES * DIV_STEPS;
    localparam int PROD_WIDTH = 2 * DATA_WIDTH;
    localparam int MAG_WIDTH  = (QUO_WIDTH > PROD_WIDTH) ? QUO_WIDTH + 1 : PROD_WIDTH + 1;

    typedef logic [DATA_WIDTH-1:0] t_word;
    typedef logic [MAG_WIDTH-1:0]  t_mag;

    localparam t_word SIGN_BIT = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam t_word POS_MAX  = ~SIGN_BIT;
    localparam t_mag  HALF_LSB = t_mag'(1) << (FRACTION_BITS - 1);

    typedef enum logic [3:0] {
        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_LT, OP_GT, OP_LE, OP_GE,
        OP_EQ, OP_NE, OP_MIN, OP_MAX, OP_INC, OP_DEC, OP_TOINT, OP_FROMINT
    } t_op;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_OVF = 2'd1,
        ST_DZ  = 2'd2
    } t_stat;

    // word that travels alongside the divider
    typedef struct packed {
        t_op                   op;
        logic                  neg;
        logic                  dz;
        logic [PROD_WIDTH-1:0] prod;
        t_word                 res;
        logic                  cmp;
        t_stat                 stat;
    } t_tag;

    function automatic t_word to_word(input logic [IO_WIDTH-1:0] v);
        logic signed [63:0] t;
        t = 64'(signed'(v));
        return t[DATA_WIDTH-1:0];
    endfunction

    function automatic logic [IO_WIDTH-1:0] to_io(input t_word v);
        logic [63:0] t;
        t = 64'(v);
        return t[IO_WIDTH-1:0];
    endfunction

    function automatic t_word sat_value(input logic neg);
        return neg ? SIGN_BIT : POS_MAX;
    endfunction

endpackage

// ===== hw/rtl/fpa_div.sv =====
module fpa_div
    import fpa_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    input  t_tag                 i_tag,
    input  logic [QUO_WIDTH-1:0] i_num,
    input  t_word                i_den,
    output logic                 o_vld,
    output t_tag                 o_tag,
    output logic [QUO_WIDTH-1:0] o_quo,
    output t_word                o_rem,
    output t_word                o_den
);

    logic                 r_vld [DIV_STAGES];
    t_tag                 r_tag [DIV_STAGES];
    logic [QUO_WIDTH-1:0] r_num [DIV_STAGES];
    logic [QUO_WIDTH-1:0] r_quo [DIV_STAGES];
    t_word                r_rem [DIV_STAGES];
    t_word                r_den [DIV_STAGES];

    genvar s;
    generate
        for (s = 0; s < DIV_STAGES; s++) begin : g_stage
            logic                 p_vld;
            t_tag                 p_tag;
            logic [QUO_WIDTH-1:0] p_num, p_quo, n_num, n_quo;
            t_word                p_rem, p_den, n_rem;

            if (s == 0) begin : g_first
                assign p_vld = i_vld;
                assign p_tag = i_tag;
                assign p_num = i_num;
                assign p_quo = '0;
                assign p_rem = '0;
                assign p_den = i_den;
            end else begin : g_next
                assign p_vld = r_vld[s-1];
                assign p_tag = r_tag[s-1];
                assign p_num = r_num[s-1];
                assign p_quo = r_quo[s-1];
                assign p_rem = r_rem[s-1];
                assign p_den = r_den[s-1];
            end

            always_comb begin
                logic [DATA_WIDTH:0] r2;
                logic                q;
                n_num = p_num;
                n_quo = p_quo;
                n_rem = p_rem;
                for (int k = 0; k < DIV_STEPS; k++) begin
                    r2    = {n_rem, n_num[QUO_WIDTH-1]};
                    n_num = n_num << 1;
                    q     = (r2 >= {1'b0, p_den});
                    if (q) begin
                        r2 = r2 - {1'b0, p_den};
                    end
                    n_rem = r2[DATA_WIDTH-1:0];
                    n_quo = {n_quo[QUO_WIDTH-2:0], q};
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[s] <= 1'b0;
                end else begin
                    r_vld[s] <= p_vld;
                end
                r_tag[s] <= p_tag;
                r_num[s] <= n_num;
                r_quo[s] <= n_quo;
                r_rem[s] <= n_rem;
                r_den[s] <= p_den;
            end
        end
    endgenerate

    assign o_vld = r_vld[DIV_STAGES-1];
    assign o_tag = r_tag[DIV_STAGES-1];
    assign o_quo = r_quo[DIV_STAGES-1];
    assign o_rem = r_rem[DIV_STAGES-1];
    assign o_den = r_den[DIV_STAGES-1];

endmodule

// ===== hw/rtl/fpa_pack.sv =====
module fpa_pack
    import fpa_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    input  t_tag                 i_tag,
    input  logic [QUO_WIDTH-1:0] i_quo,
    input  t_word                i_rem,
    input  t_word                i_den,
    output logic                 o_valid,
    output logic [IO_WIDTH-1:0]  o_result_value,
    output logic                 o_compare_true,
    output logic [1:0]           o_status
);

    logic  r_vld_a;
    t_tag  r_tag_a;
    t_mag  r_mag_a;
    t_mag  n_mag_a;
    logic  rnd;

    // round half away from zero on magnitudes
    always_comb begin
        rnd = ({i_rem, 1'b0} >= {1'b0, i_den});
        if (i_tag.op == OP_DIV) begin
            n_mag_a = t_mag'(i_quo) + t_mag'(rnd);
        end else begin
            n_mag_a = (t_mag'(i_tag.prod) + HALF_LSB) >> FRACTION_BITS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
        end else begin
            r_vld_a <= i_vld;
        end
        r_tag_a <= i_tag;
        r_mag_a <= n_mag_a;
    end

    t_word n_res;
    logic  n_cmp;
    t_stat n_stat;
    t_mag  lim;

    always_comb begin
        n_res  = r_tag_a.res;
        n_cmp  = r_tag_a.cmp;
        n_stat = r_tag_a.stat;
        lim    = r_tag_a.neg ? t_mag'(SIGN_BIT) : t_mag'(POS_MAX);
        if (r_tag_a.op == OP_MUL || r_tag_a.op == OP_DIV) begin
            n_cmp = 1'b0;
            if (r_tag_a.op == OP_DIV && r_tag_a.dz) begin
                n_res  = '0;
                n_stat = ST_DZ;
            end else if (r_mag_a > lim) begin
                n_res  = sat_value(r_tag_a.neg);
                n_stat = ST_OVF;
            end else begin
                n_res  = r_tag_a.neg ? t_word'(-r_mag_a[DATA_WIDTH-1:0])
                                     : r_mag_a[DATA_WIDTH-1:0];
                n_stat = ST_OK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_vld_a;
        end
        o_result_value <= to_io(n_res);
        o_compare_true <= n_cmp;
        o_status       <= n_stat;
    end

endmodule

// ===== hw/rtl/fixed_point_alu_q24_8.sv =====
// Signed Q24.8 fixed-point ALU. One word is taken on every cycle that start is
// high (busy never rises), and its result appears on the result ports with
// o_valid high for a single cycle, through the same pipeline for every
// opcode; results leave in the order their words came in and must be taken
// when shown. Each word passes the input register, the divider (40 quotient
// bits, four per stage over ten stages) and two stages of rounding and
// saturation. Overflows saturate with status 1, divide by zero gives 0 with
// status 2.
module fixed_point_alu_q24_8
    import fpa_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [3:0]          i_opcode,
    input  logic [IO_WIDTH-1:0] i_operand_a,
    input  logic [IO_WIDTH-1:0] i_operand_b,
    output logic                o_valid,
    output logic [IO_WIDTH-1:0] o_result_value,
    output logic                o_compare_true,
    output logic [1:0]          o_status
);

    logic  r_vld;
    t_op   r_op;
    t_word r_a, r_b;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= start & ~busy;
        end
        r_op <= t_op'(i_opcode);
        r_a  <= to_word(i_operand_a);
        r_b  <= to_word(i_operand_b);
    end

    t_tag                 n_tag;
    logic [QUO_WIDTH-1:0] n_num;
    t_word                ma, mb, sum, diff, lim_fi;
    logic                 sa, sb, lt_ab, lt_ba;

    always_comb begin
        sa    = r_a[DATA_WIDTH-1];
        sb    = r_b[DATA_WIDTH-1];
        ma    = sa ? t_word'(-r_a) : r_a;
        mb    = sb ? t_word'(-r_b) : r_b;
        sum   = r_a + r_b;
        diff  = r_a - r_b;
        lt_ab = $signed(r_a) < $signed(r_b);
        lt_ba = $signed(r_b) < $signed(r_a);
        lim_fi = (sa ? SIGN_BIT : POS_MAX) >> FRACTION_BITS;
        n_num = QUO_WIDTH'({ma, {FRACTION_BITS{1'b0}}});

        n_tag.op   = r_op;
        n_tag.neg  = sa ^ sb;
        n_tag.dz   = (mb == '0);
        n_tag.prod = ma * mb;
        n_tag.res  = '0;
        n_tag.cmp  = 1'b0;
        n_tag.stat = ST_OK;

        unique case (r_op)
            OP_ADD: begin
                if (sa == sb && sum[DATA_WIDTH-1] != sa) begin
                    n_tag.res  = sat_value(sa);
                    n_tag.stat = ST_OVF;
                end else begin
                    n_tag.res = sum;
                end
            end
            OP_SUB: begin
                if (sa != sb && diff[DATA_WIDTH-1] != sa) begin
                    n_tag.res  = sat_value(sa);
                    n_tag.stat = ST_OVF;
                end else begin
                    n_tag.res = diff;
                end
            end
            OP_MUL, OP_DIV: ;
            OP_LT:  n_tag.cmp = lt_ab;
            OP_GT:  n_tag.cmp = lt_ba;
            OP_LE:  n_tag.cmp = ~lt_ba;
            OP_GE:  n_tag.cmp = ~lt_ab;
            OP_EQ:  n_tag.cmp = (r_a == r_b);
            OP_NE:  n_tag.cmp = (r_a != r_b);
            OP_MIN: n_tag.res = lt_ab ? r_a : r_b;
            OP_MAX: n_tag.res = lt_ba ? r_a : r_b;
            OP_INC: begin
                n_tag.res = (r_a == POS_MAX) ? POS_MAX : r_a + t_word'(1);
                if (r_a == POS_MAX) n_tag.stat = ST_OVF;
            end
            OP_DEC: begin
                n_tag.res = (r_a == SIGN_BIT) ? SIGN_BIT : r_a - t_word'(1);
                if (r_a == SIGN_BIT) n_tag.stat = ST_OVF;
            end
            OP_TOINT: n_tag.res = t_word'($signed(r_a) >>> FRACTION_BITS);
            OP_FROMINT: begin
                if (ma > lim_fi) begin
                    n_tag.res  = sat_value(sa);
                    n_tag.stat = ST_OVF;
                end else begin
                    n_tag.res = sa ? t_word'(-(ma << FRACTION_BITS))
                                   : t_word'(ma << FRACTION_BITS);
                end
            end
            default: ;
        endcase
    end

    logic                 d_vld;
    t_tag                 d_tag;
    logic [QUO_WIDTH-1:0] d_quo;
    t_word                d_rem, d_den;

    fpa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_vld),
        .i_tag   (n_tag),
        .i_num   (n_num),
        .i_den   (mb),
        .o_vld   (d_vld),
        .o_tag   (d_tag),
        .o_quo   (d_quo),
        .o_rem   (d_rem),
        .o_den   (d_den)
    );

    fpa_pack u_pack (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_vld          (d_vld),
        .i_tag          (d_tag),
        .i_quo          (d_quo),
        .i_rem          (d_rem),
        .i_den          (d_den),
        .o_valid        (o_valid),
        .o_result_value (o_result_value),
        .o_compare_true (o_compare_true),
        .o_status       (o_status)
    );

endmodule

// ===== hw/rtl/fpa_chk.sv =====
module fpa_chk
    import fpa_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input logic [3:0]          i_opcode,
    input logic [IO_WIDTH-1:0] i_operand_a,
    input logic [IO_WIDTH-1:0] i_operand_b,
    input logic                o_valid,
    input logic [IO_WIDTH-1:0] o_result_value,
    input logic                o_compare_true,
    input logic [1:0]          o_status
);

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy) else $error("busy raised");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status != 2'd3) else $error("undefined status");

    a_cmp_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_compare_true |-> o_result_value == '0 && o_status == ST_OK)
        else $error("comparison word carries value or status");

    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_DZ |-> o_result_value == '0 && !o_compare_true)
        else $error("divide by zero value not zero");

    a_sat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_OVF |->
            o_result_value == {1'b1, {(IO_WIDTH-1){1'b0}}} ||
            o_result_value == {1'b0, {(IO_WIDTH-1){1'b1}}})
        else $error("overflow without saturated value");

endmodule

bind fixed_point_alu_q24_8 fpa_chk u_chk (.*);
